// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL (ssa_engine). Define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds on the clock after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/ssa_pkg.sv =====
`timescale 1ns / 1ps

package ssa_pkg;

   localparam int SLOT_W  = 10;
   localparam int COUNT_W = 11;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MIN   = 11'd2;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   typedef enum logic [1:0] {
      POOL_FULL    = 2'd0,
      POOL_PARTIAL = 2'd1,
      POOL_EMPTY   = 2'd2
   } pool_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_BAD_FREE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_EXEC   = 2'd1,
      S_RELINK = 2'd2
   } state_type;

   // Configuration seen by the engine
   typedef struct packed {
      logic               wr;        // slot_count written this cycle
      logic [COUNT_W-1:0] eff_new;   // clamped value being written
      logic [COUNT_W-1:0] eff_cur;   // clamped value of the register
   } cfg_type;

   // Clamp a slot count into 2 .. cap
   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] value,
                                                      input logic [COUNT_W-1:0] cap);
      logic [COUNT_W-1:0] n;
      n = value;
      if (n < COUNT_MIN) n = COUNT_MIN;
      if (n > cap) n = cap;
      return n;
   endfunction

endpackage

// ===== rtl/ssa_if.sv =====
`timescale 1ns / 1ps

interface ssa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [ssa_pkg::SLOT_W-1:0]  slot_in;

   modport source (output valid, output mode, output slot_in, input ready);
   modport sink   (input valid, input mode, input slot_in, output ready);
endinterface

interface ssa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ssa_pkg::SLOT_W-1:0]  slot_out;
   logic [1:0]                  status;
   logic [ssa_pkg::COUNT_W-1:0] free_slots;
   logic [1:0]                  pool_state;

   modport source (output valid, output slot_out, output status, output free_slots,
                   output pool_state, input ready);
   modport sink   (input valid, input slot_out, input status, input free_slots,
                   input pool_state, output ready);
endinterface

// ===== rtl/ssa_link_ram.sv =====
`timescale 1ns / 1ps

module ssa_link_ram #(
   parameter int DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [ssa_pkg::SLOT_W-1:0]         wr_data,
   input  logic                               rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [ssa_pkg::SLOT_W-1:0]         rd_data
);

   logic [ssa_pkg::SLOT_W-1:0] link_mem [DEPTH];
   logic [ssa_pkg::SLOT_W-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= link_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ssa_csr.sv =====
`timescale 1ns / 1ps

module ssa_csr #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready,
   output ssa_pkg::cfg_type       cfg
);

   localparam logic [ssa_pkg::COUNT_W-1:0] SLOT_CAP =
      (MAX_SLOTS < 1024) ? ssa_pkg::COUNT_W'(MAX_SLOTS) : ssa_pkg::COUNT_W'(1024);
   localparam logic ADDR_SLOT_COUNT = 1'b0;

   logic [ssa_pkg::COUNT_W-1:0] slot_count_ff;
   logic [ssa_pkg::COUNT_W-1:0] slot_count_in;
   logic                        wr_hit;

   // Decode a write beat to the slot count register
   assign wr_hit        = psel && penable && pwrite && (paddr[2] == ADDR_SLOT_COUNT);
   assign slot_count_in = pwdata[ssa_pkg::COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= ssa_pkg::COUNT_RESET;
      end else if (wr_hit) begin
         slot_count_ff <= slot_count_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == ADDR_SLOT_COUNT) ? 32'(slot_count_ff) : 32'd0;

   assign cfg.wr      = wr_hit;
   assign cfg.eff_new = ssa_pkg::clamp_count(slot_count_in, SLOT_CAP);
   assign cfg.eff_cur = ssa_pkg::clamp_count(slot_count_ff, SLOT_CAP);

endmodule

// ===== rtl/ssa_engine.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssa_engine #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   ssa_req_if.sink               req_bus,
   ssa_rsp_if.source             rsp_bus,
   input  ssa_pkg::cfg_type      cfg,
   output logic                  mem_wr_en,
   output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] mem_wr_addr,
   output logic [ssa_pkg::SLOT_W-1:0] mem_wr_data,
   output logic                  mem_rd_en,
   output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] mem_rd_addr,
   input  logic [ssa_pkg::SLOT_W-1:0] mem_rd_data
);

   localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int SW = ssa_pkg::SLOT_W;
   localparam int CW = ssa_pkg::COUNT_W;
   // Clamped slot count that the register holds right after reset
   localparam logic [CW-1:0] RESET_COUNT = (MAX_SLOTS < int'(ssa_pkg::COUNT_RESET)) ?
      CW'(MAX_SLOTS) : ssa_pkg::COUNT_RESET;

   ssa_pkg::state_type  state_ff, state_in;
   ssa_pkg::pool_type   pool_ff, pool_in;
   ssa_pkg::status_type status_in;

   logic          mode_ff;
   logic [SW-1:0] slot_ff;
   logic [SW-1:0] head_ff, head_in;
   logic [CW-1:0] free_ff, free_in;
   logic [CW-1:0] latched_ff, latched_in;
   logic [CW-1:0] ptr_ff;
   logic [CW-1:0] ptr_next;
   logic [CW-1:0] free_inc;
   logic [SW-1:0] got_in;
   logic          push_ok;
   logic          relink_last;

   logic          rsp_valid_ff;
   logic [SW-1:0] rsp_slot_ff;
   logic [1:0]    rsp_status_ff;
   logic [CW-1:0] rsp_free_ff;
   logic [1:0]    rsp_pool_ff;

   logic          accept;
   logic          commit;
   logic          relink_wr;

   assign accept      = req_bus.valid && req_bus.ready;
   assign ptr_next    = ptr_ff + CW'(1);
   assign relink_last = (ptr_next == latched_ff);
   assign free_inc    = free_ff + CW'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssa_pkg::S_IDLE: begin
            if (accept) state_in = ssa_pkg::S_EXEC;
         end
         ssa_pkg::S_EXEC: begin
            if (mode_ff == ssa_pkg::MODE_ALLOC && pool_ff == ssa_pkg::POOL_EMPTY) begin
               state_in = ssa_pkg::S_RELINK;
            end else begin
               state_in = ssa_pkg::S_IDLE;
            end
         end
         ssa_pkg::S_RELINK: begin
            if (relink_last) state_in = ssa_pkg::S_IDLE;
         end
         default: state_in = ssa_pkg::S_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_bus.ready = 1'b0;
      commit        = 1'b0;
      relink_wr     = 1'b0;
      case (state_ff)
         ssa_pkg::S_IDLE:   req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
         ssa_pkg::S_EXEC:   commit        = 1'b1;
         ssa_pkg::S_RELINK: relink_wr     = 1'b1;
         default: ;
      endcase
   end

   // Fetch the head's link on accept; data lands in time for the commit
   assign mem_rd_en   = accept;
   assign mem_rd_addr = AW'(head_ff);

   // Work out one item from the pool state and the fetched link
   always_comb begin
      head_in    = head_ff;
      free_in    = free_ff;
      pool_in    = pool_ff;
      latched_in = latched_ff;
      status_in  = ssa_pkg::ST_OK;
      got_in     = '0;
      push_ok    = 1'b0;
      if (mode_ff == ssa_pkg::MODE_ALLOC) begin
         if (pool_ff == ssa_pkg::POOL_EMPTY) begin
            latched_in = cfg.eff_cur;
            head_in    = SW'(1);
            free_in    = cfg.eff_cur - CW'(1);
            pool_in    = ssa_pkg::POOL_PARTIAL;
         end else if (pool_ff == ssa_pkg::POOL_PARTIAL && free_ff != '0) begin
            got_in  = head_ff;
            head_in = mem_rd_data;
            free_in = free_ff - CW'(1);
            if (free_ff == CW'(1)) pool_in = ssa_pkg::POOL_FULL;
         end else begin
            status_in = ssa_pkg::ST_EXHAUSTED;
         end
      end else begin
         if (pool_ff == ssa_pkg::POOL_EMPTY || {1'b0, slot_ff} >= latched_ff) begin
            status_in = ssa_pkg::ST_BAD_FREE;
         end else begin
            push_ok = 1'b1;
            head_in = slot_ff;
            free_in = free_inc;
            if (pool_ff == ssa_pkg::POOL_FULL) pool_in = ssa_pkg::POOL_PARTIAL;
            if (free_inc >= latched_ff) begin
               free_in = latched_ff;
               pool_in = ssa_pkg::POOL_EMPTY;
            end
         end
      end
   end

   // Link writes: push on free, chain sweep on relink
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = AW'(slot_ff);
      mem_wr_data = head_ff;
      if (commit && push_ok) begin
         mem_wr_en = 1'b1;
      end else if (relink_wr) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = AW'(ptr_ff);
         mem_wr_data = relink_last ? '0 : ptr_next[SW-1:0];
      end
   end

   // Control and pool registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ssa_pkg::S_IDLE;
         pool_ff    <= ssa_pkg::POOL_EMPTY;
         head_ff    <= '0;
         latched_ff <= RESET_COUNT;
         free_ff    <= RESET_COUNT;
         ptr_ff     <= CW'(1);
      end else begin
         state_ff <= state_in;
         if (commit) begin
            pool_ff    <= pool_in;
            head_ff    <= head_in;
            free_ff    <= free_in;
            latched_ff <= latched_in;
            ptr_ff     <= CW'(1);
         end else begin
            if (relink_wr) ptr_ff <= ptr_next;
            if (cfg.wr && pool_ff == ssa_pkg::POOL_EMPTY) begin
               latched_ff <= cfg.eff_new;
               free_ff    <= cfg.eff_new;
            end
         end
      end
   end

   // Hold the accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_bus.mode;
         slot_ff <= req_bus.slot_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_slot_ff   <= got_in;
         rsp_status_ff <= status_in;
         rsp_free_ff   <= free_in;
         rsp_pool_ff   <= pool_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.slot_out   = rsp_slot_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.free_slots = rsp_free_ff;
   assign rsp_bus.pool_state = rsp_pool_ff;

   `ASSERT_ALWAYS(a_free_le_latched, clock, reset, free_ff <= latched_ff, "free count above slot count")
   `ASSERT_ALWAYS(a_empty_all_free, clock, reset, pool_ff != ssa_pkg::POOL_EMPTY || free_ff == latched_ff, "empty pool with slots in use")
   `ASSERT_ALWAYS(a_full_none_free, clock, reset, pool_ff != ssa_pkg::POOL_FULL || free_ff == '0, "full pool with free slots")
   `ASSERT_ALWAYS(a_relink_in_range, clock, reset, state_ff != ssa_pkg::S_RELINK || (ptr_ff != '0 && ptr_ff < latched_ff), "relink pointer out of range")
   `ASSERT_NEXT(a_accept_commits, clock, reset, accept, state_ff == ssa_pkg::S_EXEC && !req_bus.ready, "accepted beat not committed next cycle")

endmodule

// ===== rtl/superblock_slot_allocator.sv =====
// Channel   | Dir | Handshake              | Payload
// req_bus   | in  | valid / ready          | mode, slot_in
// rsp_bus   | out | valid / ready          | slot_out, status, free_slots, pool_state
// csr (APB) | in  | psel, penable, pready  | paddr, pwdata, prdata (slot_count at 0x0)
//
// An alloc or free is accepted in S_IDLE, which starts one read of the link memory, then
// commits in S_EXEC. An alloc from an empty pool then enters S_RELINK: the single link memory
// write port rebuilds the chain one slot a cycle, slots 1 to n-1 for clamped slot count n.
// Reset is synchronous; it needs no memory clearing pass, links are written before use.
// A waiting result holds off the input: a beat is accepted only when the result register
// is empty or its beat leaves in the same cycle.
`timescale 1ns / 1ps

module superblock_slot_allocator #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   ssa_req_if.sink     req_bus,
   ssa_rsp_if.source   rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   ssa_pkg::cfg_type           cfg;
   logic                       mem_wr_en;
   logic [AW-1:0]              mem_wr_addr;
   logic [ssa_pkg::SLOT_W-1:0] mem_wr_data;
   logic                       mem_rd_en;
   logic [AW-1:0]              mem_rd_addr;
   logic [ssa_pkg::SLOT_W-1:0] mem_rd_data;

   ssa_csr #(.MAX_SLOTS(MAX_SLOTS)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ssa_link_ram #(.DEPTH(MAX_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ssa_engine #(.MAX_SLOTS(MAX_SLOTS)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .cfg         (cfg),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule
